// ===== hw/rtl/sfc_pkg.sv =====
package sfc_pkg;

   localparam int WORD_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int TCENTI_W = 15;
   localparam int HCENTI_W = 14;
   localparam int TPROD_W  = 31;   // 65535 * 17500 < 2^31
   localparam int HPROD_W  = 30;   // 65535 * 10000 < 2^30
   localparam int REM_W    = WORD_W + 1;

   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

   localparam int unsigned TEMP_SPAN   = 17500;
   localparam int unsigned HUM_SPAN    = 10000;
   localparam int unsigned TEMP_OFFSET = 4500;
   localparam int unsigned FULL_SCALE  = 65535;

   // byte roles within a frame
   localparam logic [2:0] POS_T_HI  = 3'd0;
   localparam logic [2:0] POS_T_LO  = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_HI  = 3'd3;
   localparam logic [2:0] POS_H_LO  = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   typedef struct packed {
      logic [WORD_W-1:0] temperature_word;
      logic [WORD_W-1:0] humidity_word;
      logic              crc_failed;
   } frame_type;

   typedef struct packed {
      logic [WORD_W-1:0]          temp_code;
      logic [WORD_W-1:0]          hum_code;
      logic signed [TCENTI_W-1:0] temperature_centi;
      logic [HCENTI_W-1:0]        humidity_centi;
      logic                       crc_status;
   } result_type;

   // one byte of CRC-8, MSB first, no reflection
   function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/sfc_frame.sv =====
module sfc_frame
   import sfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              frame_start,
   output logic              frame_done,
   output frame_type         frame
);

   logic [2:0]        pos_ff, pos_in, pos;
   logic [BYTE_W-1:0] crc_ff, crc_in, crc_base;
   logic [WORD_W-1:0] temp_ff, temp_in;
   logic [WORD_W-1:0] hum_ff, hum_in;
   logic              fail_ff, fail_in, fail_base;

   always_comb begin
      // a start mark or an unreachable position restarts the frame
      pos       = (frame_start || pos_ff > POS_H_CRC) ? POS_T_HI : pos_ff;
      crc_base  = (pos == POS_T_HI) ? CRC_INIT : crc_ff;
      fail_base = (pos == POS_T_HI) ? 1'b0 : fail_ff;

      pos_in  = (pos == POS_H_CRC) ? POS_T_HI : pos + 3'd1;
      crc_in  = crc_base;
      temp_in = temp_ff;
      hum_in  = hum_ff;
      fail_in = fail_base;

      case (pos)
         POS_T_HI: begin
            temp_in = {data_byte, temp_ff[BYTE_W-1:0]};
            crc_in  = crc_step(crc_base, data_byte);
         end
         POS_T_LO: begin
            temp_in = {temp_ff[WORD_W-1:BYTE_W], data_byte};
            crc_in  = crc_step(crc_base, data_byte);
         end
         POS_H_HI: begin
            hum_in = {data_byte, hum_ff[BYTE_W-1:0]};
            crc_in = crc_step(crc_base, data_byte);
         end
         POS_H_LO: begin
            hum_in = {hum_ff[WORD_W-1:BYTE_W], data_byte};
            crc_in = crc_step(crc_base, data_byte);
         end
         default: begin
            // check byte
            if (crc_base != data_byte) begin
               fail_in = 1'b1;
            end
            crc_in = CRC_INIT;
         end
      endcase

      frame_done             = (pos == POS_H_CRC);
      frame.temperature_word = temp_ff;
      frame.humidity_word    = hum_ff;
      frame.crc_failed       = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_T_HI;
         crc_ff  <= CRC_INIT;
         temp_ff <= '0;
         hum_ff  <= '0;
         fail_ff <= 1'b0;
      end else if (byte_valid) begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         temp_ff <= temp_in;
         hum_ff  <= hum_in;
         fail_ff <= fail_in;
      end
   end

endmodule

// ===== hw/rtl/sfc_scale.sv =====
module sfc_scale
   import sfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       frame_valid,
   input  frame_type  frame,
   output logic       frame_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic               s2_valid_ff, s2_valid_in;
   logic [TPROD_W-1:0] t_prod_ff;
   logic [HPROD_W-1:0] h_prod_ff;
   logic [WORD_W-1:0]  t_raw_ff, h_raw_ff;
   logic               fail_ff;

   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   logic               out_free, s2_free;

   logic [TCENTI_W-1:0] t_q0, t_q;
   logic [REM_W-1:0]    t_r0;
   logic [HCENTI_W-1:0] h_q0, h_q;
   logic [REM_W-1:0]    h_r0;

   assign out_free    = !out_valid_ff || out_ready;
   assign s2_free     = !s2_valid_ff || out_free;
   assign frame_ready = s2_free;

   assign s2_valid_in  = s2_free ? frame_valid : s2_valid_ff;
   assign out_valid_in = out_free ? s2_valid_ff : out_valid_ff;

   // x / 65535: with q0 = x >> 16, x = q0*65535 + (lo + q0), and lo + q0 < 2*65535
   always_comb begin
      t_q0 = t_prod_ff[TPROD_W-1:WORD_W];
      t_r0 = {1'b0, t_prod_ff[WORD_W-1:0]} + REM_W'(t_q0);
      t_q  = t_q0 + TCENTI_W'(t_r0 >= REM_W'(FULL_SCALE));

      h_q0 = h_prod_ff[HPROD_W-1:WORD_W];
      h_r0 = {1'b0, h_prod_ff[WORD_W-1:0]} + REM_W'(h_q0);
      h_q  = h_q0 + HCENTI_W'(h_r0 >= REM_W'(FULL_SCALE));

      out_in.temp_code         = t_raw_ff;
      out_in.hum_code          = h_raw_ff;
      out_in.temperature_centi = signed'(t_q - TCENTI_W'(TEMP_OFFSET));
      out_in.humidity_centi    = h_q;
      out_in.crc_status        = fail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_valid && s2_free) begin
         t_prod_ff <= TPROD_W'({{(TPROD_W-WORD_W){1'b0}}, frame.temperature_word}
                               * TPROD_W'(TEMP_SPAN));
         h_prod_ff <= HPROD_W'({{(HPROD_W-WORD_W){1'b0}}, frame.humidity_word}
                               * HPROD_W'(HUM_SPAN));
         t_raw_ff  <= frame.temperature_word;
         h_raw_ff  <= frame.humidity_word;
         fail_ff   <= frame.crc_failed;
      end
      if (s2_valid_ff && out_free) begin
         out_ff <= out_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

// ===== hw/rtl/sensor_frame_crc_convert.sv =====
// Measurement frame CRC check and conversion, one frame byte per word.
// Throughput: one byte per cycle; a frame's last byte stalls only while the product and
// output stages both hold results.
// Path: after the last byte is accepted, the result passes through the input register, the
// product register and the output register, in that order.
// Reset: synchronous, active high; clears the byte position, the words and all valid
// flags and sets the running CRC to 0xFF, so the next byte is taken as byte 0 of a frame.
module sensor_frame_crc_convert
   import sfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] temp_code, [31:16] hum_code,
                                    // [46:32] temperature_centi, [60:47] humidity_centi,
                                    // [63:61] zero
   output logic        rsp_tuser    // [0] crc_status
);

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_start_ff;
   logic              s1_adv;

   logic              frame_done;
   frame_type         frame;
   logic              scale_ready;
   result_type        result;

   // a byte that closes a frame waits only if the product stage is full
   assign s1_adv      = s1_valid_ff && (!frame_done || scale_ready);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff  <= req_tdata;
         s1_start_ff <= req_tuser;
      end
   end

   sfc_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (s1_adv),
      .data_byte   (s1_byte_ff),
      .frame_start (s1_start_ff),
      .frame_done  (frame_done),
      .frame       (frame)
   );

   sfc_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (s1_adv && frame_done),
      .frame       (frame),
      .frame_ready (scale_ready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   assign rsp_tdata = {3'b000, result.humidity_centi, result.temperature_centi,
                       result.hum_code, result.temp_code};
   assign rsp_tuser = result.crc_status;

endmodule

// ===== hw/rtl/sfc_checker.sv =====
module sfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)
                                       && $stable(req_tuser)))
      else $error("request word changed while stalled");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("result word changed while stalled");

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // humidity stays within 0..100.00 percent
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[60:47] <= 14'd10000))
      else $error("humidity out of range");

   // temperature stays within -45.00..130.00
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[46:32]) >= -15'sd4500
                      && $signed(rsp_tdata[46:32]) <= 15'sd13000))
      else $error("temperature out of range");

endmodule

bind sensor_frame_crc_convert sfc_checker u_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb
   import sfc_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic        req_tuser = 1'b0;  // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [15:0] temp_code, [31:16] hum_code,
                                   // [46:32] temperature_centi, [60:47] humidity_centi
   logic        rsp_tuser;         // [0] crc_status

   sensor_frame_crc_convert u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // frame decoder state, mirrors the block after reset
   logic [2:0]  rx_pos  = POS_T_HI;
   logic [7:0]  rx_crc  = CRC_INIT;
   logic [15:0] t_word  = '0;
   logic [15:0] h_word  = '0;
   logic        crc_bad = 1'b0;

   result_type  pending_readings[$];
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   int          rx_wait = 0;

   function automatic int draw_wait(input bit enabled);
      if (!enabled || $urandom_range(0, 1) == 0) begin
         return 0;
      end
      return $urandom_range(1, 18);
   endfunction

   // bitwise form: feedback = msb of crc xor incoming data bit
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[7] ^ d[i];
         crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

   function automatic logic [7:0] word_crc(input logic [15:0] w);
      return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   task automatic decode_frame_byte(input logic [7:0] b, input logic start);
      logic [2:0]  slot;
      logic [31:0] t_scaled;
      logic [31:0] h_scaled;
      result_type  r;
      slot = rx_pos;
      if (start || slot > POS_H_CRC) begin
         slot = POS_T_HI;
      end
      if (slot == POS_T_HI) begin
         rx_crc  = CRC_INIT;
         crc_bad = 1'b0;
      end
      case (slot)
         POS_T_HI: begin
            t_word[15:8] = b;
            rx_crc = crc8_next(rx_crc, b);
         end
         POS_T_LO: begin
            t_word[7:0] = b;
            rx_crc = crc8_next(rx_crc, b);
         end
         POS_H_HI: begin
            h_word[15:8] = b;
            rx_crc = crc8_next(rx_crc, b);
         end
         POS_H_LO: begin
            h_word[7:0] = b;
            rx_crc = crc8_next(rx_crc, b);
         end
         default: begin
            if (rx_crc != b) begin
               crc_bad = 1'b1;
            end
            rx_crc = CRC_INIT;
         end
      endcase
      if (slot == POS_H_CRC) begin
         t_scaled = (32'(t_word) * TEMP_SPAN) / FULL_SCALE;
         h_scaled = (32'(h_word) * HUM_SPAN) / FULL_SCALE;
         r.temp_code         = t_word;
         r.hum_code          = h_word;
         r.temperature_centi = 15'(t_scaled - TEMP_OFFSET);
         r.humidity_centi    = 14'(h_scaled);
         r.crc_status        = crc_bad;
         pending_readings.push_back(r);
         rx_pos = POS_T_HI;
      end else begin
         rx_pos = slot + 3'd1;
      end
   endtask

   // valid is only lowered when a gap follows, so it never gets two updates in one step
   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      gap = draw_wait(tx_idle_on);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      decode_frame_byte(b, start);
   endtask

   task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input bit mark,
                             input bit bad_t, input bit bad_h);
      logic [7:0] tc;
      logic [7:0] hc;
      tc = word_crc(t) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
      hc = word_crc(h) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
      send_byte(t[15:8], mark);
      send_byte(t[7:0], 1'b0);
      send_byte(tc, 1'b0);
      send_byte(h[15:8], 1'b0);
      send_byte(h[7:0], 1'b0);
      send_byte(hc, 1'b0);
   endtask

   // always lets one edge pass, so the next send starts in a later step
   task automatic wait_for_readings();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_reading();
      result_type want;
      if (pending_readings.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b",
                  $time, rsp_tdata, rsp_tuser);
         error_count++;
      end else begin
         want = pending_readings.pop_front();
         compare_field("temp_code", want.temp_code, rsp_tdata[15:0]);
         compare_field("hum_code", want.hum_code, rsp_tdata[31:16]);
         compare_field("temperature_centi", $unsigned(want.temperature_centi),
                       rsp_tdata[46:32]);
         compare_field("humidity_centi", want.humidity_centi, rsp_tdata[60:47]);
         compare_field("crc_status", want.crc_status, rsp_tuser);
      end
   endtask

   // result side: check each word, then stall for a drawn number of cycles, which may be zero
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
      end else if (rsp_tready) begin
         if (rsp_tvalid) begin
            check_reading();
            rx_wait = draw_wait(rx_idle_on);
            if (rx_wait != 0) begin
               rsp_tready <= 1'b0;
            end
         end
      end else if (rx_wait > 1) begin
         rx_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_extremes();
      send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
      // no start mark: position counter wraps on its own
      send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_crc_mismatch();
      send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b0);
   endtask

   task automatic test_restart_mid_frame();
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_frame(16'h6666, 16'h1234, 1'b1, 1'b0, 1'b1);
   endtask

   task automatic test_random_traffic();
      int unsigned first;
      int unsigned n;
      int          pick;
      bit          drained;
      logic [15:0] t;
      logic [15:0] h;
      first   = bytes_sent;
      drained = 1'b0;
      while (bytes_sent - first < 1700) begin
         if (!drained && bytes_sent - first > 850) begin
            wait_for_readings();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 19);
         t = 16'($urandom);
         h = 16'($urandom);
         if ($urandom_range(0, 15) == 0) t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         if ($urandom_range(0, 15) == 0) h = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         if (pick < 15) begin
            send_frame(t, h, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 7) == 0);
         end else if (pick < 17) begin
            // broken frame: cut short, then a marked frame takes over
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
               send_byte(8'($urandom), i == 0);
            end
            send_frame(t, h, 1'b1, 1'b0, $urandom_range(0, 7) == 0);
         end else if (pick < 19) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
         end else begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
         end
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_crc_mismatch();
      test_restart_mid_frame();
      wait_for_readings();
      test_random_traffic();
      wait_for_readings();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
